// ----- rtl/script_source_tokenizer_core_macros.svh -----
// Assertion helpers for the RTL file that checks itself.
`ifndef SCRIPT_SOURCE_TOKENIZER_CORE_MACROS_SVH
`define SCRIPT_SOURCE_TOKENIZER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

  localparam int OffW    = 24;
  localparam int LenW    = 16;
  localparam int LineW   = 20;
  localparam int ValW    = 31;
  localparam int KindW   = 6;
  localparam int NumTok  = 3;
  localparam int TokIdxW = $clog2(NumTok);
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int NumKw   = 9;

  localparam logic [OffW-1:0]  OffMax  = {OffW{1'b1}};
  localparam logic [LenW-1:0]  LenMax  = {LenW{1'b1}};
  localparam logic [LineW-1:0] LineMax = {LineW{1'b1}};
  localparam logic [ValW-1:0]  ValMax  = {ValW{1'b1}};

  localparam logic [KindW-1:0] KindEnd    = 6'd0;
  localparam logic [KindW-1:0] KindNone   = 6'd0;  // no symbol spelled
  localparam logic [KindW-1:0] KindIdent  = 6'd1;
  localparam logic [KindW-1:0] KindInt    = 6'd2;
  localparam logic [KindW-1:0] KindFloat  = 6'd3;
  localparam logic [KindW-1:0] KindDq     = 6'd4;
  localparam logic [KindW-1:0] KindSq     = 6'd5;
  localparam logic [KindW-1:0] KindKw0    = 6'd6;
  localparam logic [KindW-1:0] KindSeq3   = 6'd15;
  localparam logic [KindW-1:0] KindSne3   = 6'd16;
  localparam logic [KindW-1:0] KindAddEq  = 6'd17;
  localparam logic [KindW-1:0] KindSubEq  = 6'd18;
  localparam logic [KindW-1:0] KindMulEq  = 6'd19;
  localparam logic [KindW-1:0] KindDivEq  = 6'd20;
  localparam logic [KindW-1:0] KindInc    = 6'd21;
  localparam logic [KindW-1:0] KindDec    = 6'd22;
  localparam logic [KindW-1:0] KindModEq  = 6'd23;
  localparam logic [KindW-1:0] KindOrEq   = 6'd24;
  localparam logic [KindW-1:0] KindAndEq  = 6'd25;
  localparam logic [KindW-1:0] KindXorEq  = 6'd26;
  localparam logic [KindW-1:0] KindShr    = 6'd27;
  localparam logic [KindW-1:0] KindShl    = 6'd28;
  localparam logic [KindW-1:0] KindArrow  = 6'd29;
  localparam logic [KindW-1:0] KindPlus   = 6'd30;
  localparam logic [KindW-1:0] KindMinus  = 6'd31;
  localparam logic [KindW-1:0] KindSlash  = 6'd32;
  localparam logic [KindW-1:0] KindStar   = 6'd33;
  localparam logic [KindW-1:0] KindLParen = 6'd34;
  localparam logic [KindW-1:0] KindRParen = 6'd35;
  localparam logic [KindW-1:0] KindLBrack = 6'd36;
  localparam logic [KindW-1:0] KindRBrack = 6'd37;
  localparam logic [KindW-1:0] KindLBrace = 6'd38;
  localparam logic [KindW-1:0] KindRBrace = 6'd39;
  localparam logic [KindW-1:0] KindPct    = 6'd40;
  localparam logic [KindW-1:0] KindCaret  = 6'd41;
  localparam logic [KindW-1:0] KindAmp    = 6'd42;
  localparam logic [KindW-1:0] KindDot    = 6'd43;
  localparam logic [KindW-1:0] KindComma  = 6'd44;
  localparam logic [KindW-1:0] KindAssign = 6'd45;
  localparam logic [KindW-1:0] KindSemi   = 6'd46;
  localparam logic [KindW-1:0] KindColon  = 6'd47;
  localparam logic [KindW-1:0] KindErr    = 6'd48;

  typedef enum logic [5:0] {
    ModeIdle  = 6'b000001,
    ModeSym   = 6'b000010,
    ModeIdent = 6'b000100,
    ModeNum   = 6'b001000,
    ModeDq    = 6'b010000,
    ModeSq    = 6'b100000
  } mode_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [OffW-1:0]  start;
    logic [LenW-1:0]  len;
    logic [ValW-1:0]  val;
  } tok_t;

  // All tokens closed by one source byte, sharing one line number.
  typedef struct packed {
    tok_t [NumTok-1:0]  toks;
    logic [TokIdxW-1:0] cnt;
    logic [LineW-1:0]   line;
  } bundle_t;

  function automatic logic [KindW-1:0] sym1(input logic [7:0] c);
    case (c)
      "+": sym1 = KindPlus;
      "-": sym1 = KindMinus;
      "/": sym1 = KindSlash;
      "*": sym1 = KindStar;
      "(": sym1 = KindLParen;
      ")": sym1 = KindRParen;
      "[": sym1 = KindLBrack;
      "]": sym1 = KindRBrack;
      "{": sym1 = KindLBrace;
      "}": sym1 = KindRBrace;
      "%": sym1 = KindPct;
      "^": sym1 = KindCaret;
      "&": sym1 = KindAmp;
      ".": sym1 = KindDot;
      ",": sym1 = KindComma;
      "=": sym1 = KindAssign;
      ";": sym1 = KindSemi;
      ":": sym1 = KindColon;
      default: sym1 = KindNone;
    endcase
  endfunction

  function automatic logic [KindW-1:0] sym2(input logic [7:0] a, input logic [7:0] b);
    case ({a, b})
      "+=": sym2 = KindAddEq;
      "-=": sym2 = KindSubEq;
      "*=": sym2 = KindMulEq;
      "/=": sym2 = KindDivEq;
      "++": sym2 = KindInc;
      "--": sym2 = KindDec;
      "%=": sym2 = KindModEq;
      "|=": sym2 = KindOrEq;
      "&=": sym2 = KindAndEq;
      "^=": sym2 = KindXorEq;
      ">>": sym2 = KindShr;
      "<<": sym2 = KindShl;
      "=>": sym2 = KindArrow;
      default: sym2 = KindNone;
    endcase
  endfunction

  // Bytes that begin some longer symbol.
  function automatic logic sym_prefix1(input logic [7:0] c);
    case (c)
      "=", "!", "+", "-", "*", "/", "%", "|", "&", "^", ">", "<": sym_prefix1 = 1'b1;
      default: sym_prefix1 = 1'b0;
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    case (k)
      4'd0: kw_len = 4'd8;
      4'd1: kw_len = 4'd3;
      4'd2: kw_len = 4'd5;
      4'd3: kw_len = 4'd3;
      4'd4: kw_len = 4'd6;
      4'd5: kw_len = 4'd3;
      4'd6: kw_len = 4'd5;
      4'd7: kw_len = 4'd8;
      4'd8: kw_len = 4'd5;
      default: kw_len = 4'd0;
    endcase
  endfunction

  // Byte i of keyword k; text is left-aligned in 64 bits.
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] i);
    logic [63:0] t;
    case (k)
      4'd0: t = "function";
      4'd1: t = {"let", 40'h0};
      4'd2: t = {"const", 24'h0};
      4'd3: t = {"var", 40'h0};
      4'd4: t = {"return", 16'h0};
      4'd5: t = {"for", 40'h0};
      4'd6: t = {"while", 24'h0};
      4'd7: t = "continue";
      4'd8: t = {"break", 24'h0};
      default: t = '0;
    endcase
    kw_char = t[63 - 8 * i -: 8];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sst_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sst_front import sst_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] char_byte_i,
  input  wire logic       end_of_input_i,
  output bundle_t         bundle_o,
  output logic            push_o
);

  mode_e             mode_q, mode_d;
  logic [15:0]       pend_q, pend_d;
  logic [NumKw-1:0]  cand_q, cand_d;
  logic [OffW-1:0]   start_q, start_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [OffW-1:0]   off_q, off_d;
  logic [LineW-1:0]  line_q, line_d;
  logic [ValW-1:0]   val_q, val_d;
  logic              per_q, per_d;

  tok_t [NumTok-1:0]  toks;
  logic [TokIdxW-1:0] ntok;
  logic               do_idle;
  logic [7:0]         c;
  logic [7:0]         pa, pb;
  logic               is_alpha, is_digit;
  logic [KindW-1:0]   ident_kind;
  logic [LenW-1:0]    len_inc;
  logic [34:0]        prod;

  function automatic logic [OffW-1:0] off_inc(input logic [OffW-1:0] a);
    off_inc = (a == OffMax) ? a : a + 1'b1;
  endfunction

  function automatic tok_t mk_tok(input logic [KindW-1:0] kind, input logic [OffW-1:0] start,
                                  input logic [LenW-1:0] len, input logic [ValW-1:0] val);
    tok_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.val   = val;
    mk_tok  = t;
  endfunction

  assign c        = char_byte_i;
  assign pa       = pend_q[7:0];
  assign pb       = pend_q[15:8];
  assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_digit = (c >= "0" && c <= "9");
  assign len_inc  = (len_q == LenMax) ? len_q : len_q + 1'b1;
  assign prod     = {1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0} + {31'b0, c[3:0]};

  // A later keyword wins when two survive to the same length.
  always_comb begin
    ident_kind = KindIdent;
    for (int k = 0; k < NumKw; k++) begin
      if (cand_q[k] && len_q == LenW'(kw_len(4'(k)))) begin
        ident_kind = KindW'(KindKw0 + KindW'(k));
      end
    end
  end

  always_comb begin
    mode_d  = mode_q;
    pend_d  = pend_q;
    cand_d  = cand_q;
    start_d = start_q;
    len_d   = len_q;
    off_d   = off_q;
    line_d  = line_q;
    val_d   = val_q;
    per_d   = per_q;
    toks    = '0;
    ntok    = '0;
    do_idle = 1'b0;
    if (accept_i) begin
      if (end_of_input_i) begin
        case (mode_q)
          ModeSym: begin
            if (sym1(pa) != KindNone) begin
              toks[ntok] = mk_tok(sym1(pa), start_q, LenW'(1), '0);
              ntok = ntok + 1'b1;
            end
            if (len_q > LenW'(1) && sym1(pb) != KindNone) begin
              toks[ntok] = mk_tok(sym1(pb), off_inc(start_q), LenW'(1), '0);
              ntok = ntok + 1'b1;
            end
          end
          ModeIdent: begin
            toks[ntok] = mk_tok(ident_kind, start_q, len_q, '0);
            ntok = ntok + 1'b1;
          end
          ModeNum: begin
            toks[ntok] = mk_tok(per_q ? KindFloat : KindInt, start_q, len_q,
                                per_q ? '0 : val_q);
            ntok = ntok + 1'b1;
          end
          ModeDq, ModeSq: begin
            toks[ntok] = mk_tok(KindErr, start_q, len_q, '0);
            ntok = ntok + 1'b1;
          end
          default: ;
        endcase
        toks[ntok] = mk_tok(KindEnd, off_q, '0, '0);
        ntok = ntok + 1'b1;
        mode_d  = ModeIdle;
        pend_d  = '0;
        cand_d  = '0;
        start_d = '0;
        len_d   = '0;
        off_d   = '0;
        line_d  = '0;
        val_d   = '0;
        per_d   = 1'b0;
      end else begin
        off_d = off_inc(off_q);
        case (mode_q)
          ModeSym: begin
            if (len_q == LenW'(1)) begin
              if ({pa, c} == "==" || {pa, c} == "!=") begin
                pend_d = {c, pa};
                len_d  = LenW'(2);
              end else if (sym2(pa, c) != KindNone) begin
                toks[ntok] = mk_tok(sym2(pa, c), start_q, LenW'(2), '0);
                ntok = ntok + 1'b1;
                mode_d = ModeIdle;
              end else begin
                if (sym1(pa) != KindNone) begin
                  toks[ntok] = mk_tok(sym1(pa), start_q, LenW'(1), '0);
                  ntok = ntok + 1'b1;
                end
                do_idle = 1'b1;
              end
            end else begin
              // Pending text is "==" or "!=".
              if (c == "=") begin
                toks[ntok] = mk_tok((pa == "=") ? KindSeq3 : KindSne3, start_q,
                                    LenW'(3), '0);
                ntok = ntok + 1'b1;
                mode_d = ModeIdle;
              end else begin
                if (sym1(pa) != KindNone) begin
                  toks[ntok] = mk_tok(sym1(pa), start_q, LenW'(1), '0);
                  ntok = ntok + 1'b1;
                end
                if (c == ">") begin
                  toks[ntok] = mk_tok(KindArrow, off_inc(start_q), LenW'(2), '0);
                  ntok = ntok + 1'b1;
                  mode_d = ModeIdle;
                end else begin
                  toks[ntok] = mk_tok(KindAssign, off_inc(start_q), LenW'(1), '0);
                  ntok = ntok + 1'b1;
                  do_idle = 1'b1;
                end
              end
            end
          end
          ModeIdent: begin
            if (is_alpha || is_digit) begin
              for (int k = 0; k < NumKw; k++) begin
                cand_d[k] = cand_q[k] && (len_q < LenW'(kw_len(4'(k)))) &&
                            (kw_char(4'(k), len_q[2:0]) == c);
              end
              len_d = len_inc;
            end else begin
              toks[ntok] = mk_tok(ident_kind, start_q, len_q, '0);
              ntok = ntok + 1'b1;
              do_idle = 1'b1;
            end
          end
          ModeNum: begin
            if (is_digit) begin
              if (!per_q) begin
                val_d = (prod > {4'b0, ValMax}) ? ValMax : prod[ValW-1:0];
              end
              len_d = len_inc;
            end else if (c == ".") begin
              len_d = len_inc;
              if (per_q) begin
                toks[ntok] = mk_tok(KindErr, start_q, len_inc, '0);
                ntok = ntok + 1'b1;
                mode_d = ModeIdle;
              end else begin
                per_d = 1'b1;
              end
            end else begin
              toks[ntok] = mk_tok(per_q ? KindFloat : KindInt, start_q, len_q,
                                  per_q ? '0 : val_q);
              ntok = ntok + 1'b1;
              do_idle = 1'b1;
            end
          end
          ModeDq, ModeSq: begin
            len_d = len_inc;
            if ((mode_q == ModeDq && c == "\"") || (mode_q == ModeSq && c == "'")) begin
              toks[ntok] = mk_tok((mode_q == ModeDq) ? KindDq : KindSq, start_q,
                                  len_inc, '0);
              ntok = ntok + 1'b1;
              mode_d = ModeIdle;
            end
          end
          default: do_idle = 1'b1;
        endcase

        // The current byte starts over from between tokens.
        if (do_idle) begin
          mode_d = ModeIdle;
          if (c == "\"" || c == "'") begin
            mode_d  = (c == "\"") ? ModeDq : ModeSq;
            start_d = off_q;
            len_d   = LenW'(1);
          end else if (is_alpha) begin
            mode_d  = ModeIdent;
            start_d = off_q;
            len_d   = LenW'(1);
            for (int k = 0; k < NumKw; k++) begin
              cand_d[k] = (kw_char(4'(k), 3'd0) == c);
            end
          end else if (is_digit) begin
            mode_d  = ModeNum;
            start_d = off_q;
            len_d   = LenW'(1);
            val_d   = ValW'(c[3:0]);
            per_d   = 1'b0;
          end else if (sym_prefix1(c)) begin
            mode_d  = ModeSym;
            start_d = off_q;
            len_d   = LenW'(1);
            pend_d  = {8'h00, c};
          end else if (sym1(c) != KindNone) begin
            toks[ntok] = mk_tok(sym1(c), off_q, LenW'(1), '0);
            ntok = ntok + 1'b1;
          end else if (c == 8'h0a) begin
            line_d = (line_q == LineMax) ? line_q : line_q + 1'b1;
          end
        end
      end
    end
  end

  assign bundle_o.toks = toks;
  assign bundle_o.cnt  = ntok;
  assign bundle_o.line = line_q;
  assign push_o        = accept_i && (ntok != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      pend_q  <= '0;
      cand_q  <= '0;
      start_q <= '0;
      len_q   <= '0;
      off_q   <= '0;
      line_q  <= '0;
      val_q   <= '0;
      per_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      cand_q  <= cand_d;
      start_q <= start_d;
      len_q   <= len_d;
      off_q   <= off_d;
      line_q  <= line_d;
      val_q   <= val_d;
      per_q   <= per_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sst_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sst_queue import sst_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire bundle_t  bundle_i,
  input  wire logic     pop_i,
  output bundle_t       head_o,
  output logic          full_o,
  output logic          nonempty_o
);

  bundle_t [QDepth-1:0] mem_q;
  logic [QPtrW-1:0]     wr_q, rd_q;
  logic [QPtrW:0]       cnt_q, cnt_d;

  assign head_o     = mem_q[rd_q];
  assign full_o     = (cnt_q == (QPtrW + 1)'(QDepth));
  assign nonempty_o = (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sst_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sst_back import sst_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bundle_t           head_i,
  input  wire logic              nonempty_i,
  input  wire logic              out_stall_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  output logic [KindW-1:0]       token_kind_o,
  output logic [OffW-1:0]        start_offset_o,
  output logic [LenW-1:0]        token_length_o,
  output logic [LineW-1:0]       line_number_o,
  output logic [ValW-1:0]        int_value_o,
  output logic                   last_of_run_o
);

  logic [TokIdxW-1:0] idx_q;
  tok_t               tok;
  logic               beat;
  logic               last;

  assign tok  = head_i.toks[idx_q];
  assign last = (idx_q == head_i.cnt - 1'b1);
  assign beat = nonempty_i && !out_stall_i;

  assign out_valid_o    = nonempty_i;
  assign token_kind_o   = tok.kind;
  assign start_offset_o = tok.start;
  assign token_length_o = tok.len;
  assign line_number_o  = head_i.line;
  assign int_value_o    = tok.val;
  assign last_of_run_o  = last;
  assign pop_o          = beat && last;

  // Walk the tokens of the head bundle, one per beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (beat) begin
      idx_q <= last ? '0 : idx_q + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/script_source_tokenizer_core.sv -----
// Streaming source tokenizer: takes one source byte per cycle unless in_stall_o is
// high, and hands out one token per output beat. Each accepted byte closes zero to
// three tokens; they are collected as one bundle and placed in a four-bundle queue,
// and the output side walks each bundle one token per unstalled cycle. Input is
// held off only while that queue is full, which happens when the output is
// stalled or when tokens are closed faster than one per byte. The end-of-input
// beat flushes the open token, sends the end token and returns all counters to
// zero. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "script_source_tokenizer_core_macros.svh"

module script_source_tokenizer_core import sst_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        char_byte_i,
  input  wire logic              end_of_input_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [KindW-1:0]       token_kind_o,
  output logic [OffW-1:0]        start_offset_o,
  output logic [LenW-1:0]        token_length_o,
  output logic [LineW-1:0]       line_number_o,
  output logic [ValW-1:0]        int_value_o,
  output logic                   last_of_run_o
);

  bundle_t bundle, head;
  logic    push, pop, full, nonempty, accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  sst_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .char_byte_i    (char_byte_i),
    .end_of_input_i (end_of_input_i),
    .bundle_o       (bundle),
    .push_o         (push)
  );

  sst_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .bundle_i   (bundle),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (full),
    .nonempty_o (nonempty)
  );

  sst_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .nonempty_i     (nonempty),
    .out_stall_i    (out_stall_i),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .token_kind_o   (token_kind_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .line_number_o  (line_number_o),
    .int_value_o    (int_value_o),
    .last_of_run_o  (last_of_run_o)
  );

  `SST_ASSERT_NOW(a_full_offers, in_stall_o, out_valid_o, "queue full without output")
  `SST_ASSERT_NOW(a_end_is_last, out_valid_o && token_kind_o == KindEnd, last_of_run_o,
                  "end token not last of its run")
  `SST_ASSERT_NEXT(a_run_continues, out_valid_o && !out_stall_i && !last_of_run_o,
                   out_valid_o, "run broken before its last token")

endmodule

`default_nettype wire
